// ===== hdl/sip_pkg.sv =====
// ----------------------------------------------------------------------------
// sip_pkg
// Shared types, constants and round functions for the SipHash-2-4 stream block.
// ----------------------------------------------------------------------------
package sip_pkg;

  localparam int unsigned LANE_W = 64;
  localparam int unsigned CNT_W  = 4;

  localparam logic [LANE_W-1:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [LANE_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [LANE_W-1:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [LANE_W-1:0] SIP_C3 = 64'h7465646279746573;

  localparam logic [LANE_W-1:0] KEY_LOW_RST  = 64'h0706050403020100;
  localparam logic [LANE_W-1:0] KEY_HIGH_RST = 64'h0f0e0d0c0b0a0908;

  localparam logic [7:0] FIN_MASK = 8'hff;

  // each SipRound is two half-round steps
  localparam logic [CNT_W-1:0] COMP_LAST = 4'd3;
  localparam logic [CNT_W-1:0] FIN_LAST  = 4'd11;

  typedef enum logic [0:0] {
    REQ_ABSORB = 1'b0,
    REQ_FINISH = 1'b1
  } req_type_e;

  typedef enum logic [0:0] {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [LANE_W-1:0] a;
    logic [LANE_W-1:0] b;
    logic [LANE_W-1:0] c;
    logic [LANE_W-1:0] d;
  } lanes_t;

  typedef struct packed {
    logic accept;
    logic half;
    logic half_sel;
    logic xor_msg;
    logic xor_fin;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic word_full;
  } dp_stat_t;

  function automatic logic [LANE_W-1:0] rotl(input logic [LANE_W-1:0] x,
                                             input logic [5:0] r);
    rotl = (x << r) | (x >> (7'd64 - {1'b0, r}));
  endfunction

  function automatic lanes_t half_round0(input lanes_t s);
    lanes_t o;
    logic [LANE_W-1:0] a1;
    logic [LANE_W-1:0] c1;
    a1  = s.a + s.b;
    c1  = s.c + s.d;
    o.b = rotl(s.b, 6'd13) ^ a1;
    o.a = rotl(a1, 6'd32);
    o.d = rotl(s.d, 6'd16) ^ c1;
    o.c = c1;
    half_round0 = o;
  endfunction

  function automatic lanes_t half_round1(input lanes_t s);
    lanes_t o;
    logic [LANE_W-1:0] c2;
    o.a = s.a + s.d;
    c2  = s.c + s.b;
    o.d = rotl(s.d, 6'd21) ^ o.a;
    o.b = rotl(s.b, 6'd17) ^ c2;
    o.c = rotl(c2, 6'd32);
    half_round1 = o;
  endfunction

endpackage

// ===== hdl/sip_ctrl.sv =====
// ----------------------------------------------------------------------------
// sip_ctrl
// Sequencer: accepts transactions, steps the half-round counter, owns the
// result valid flag.
// ----------------------------------------------------------------------------
module sip_ctrl
  import sip_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     req_type_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             fin_q, fin_d;
  logic             valid_q, valid_d;
  logic             in_fire;
  logic             out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = valid_q;
  assign out_free    = ~valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_d = '0;
          fin_d = (req_type_i == REQ_FINISH);
          if ((req_type_i == REQ_FINISH) || stat_i.word_full) begin
            state_d = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        cnt_d = cnt_q + 1'b1;
        if (!fin_q && (cnt_q == COMP_LAST)) begin
          state_d = ST_IDLE;
        end else if (fin_q && (cnt_q == FIN_LAST)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    valid_d  = valid_q & ~out_ready_i;
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_fire;
      end
      ST_ROUND: begin
        cmd_o.half     = 1'b1;
        cmd_o.half_sel = cnt_q[0];
        cmd_o.xor_msg  = (cnt_q == COMP_LAST);
        cmd_o.xor_fin  = (cnt_q == COMP_LAST) & fin_q;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          valid_d    = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      fin_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
      valid_q <= valid_d;
    end
  end

endmodule

// ===== hdl/sip_datapath.sv =====
// ----------------------------------------------------------------------------
// sip_datapath
// Key registers, four lanes, word buffer, byte and length counters, shared
// half-round unit and digest register.
// ----------------------------------------------------------------------------
module sip_datapath
  import sip_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_index_i,
  input  logic [LANE_W-1:0] cfg_data_i,
  input  logic              req_type_i,
  input  logic [7:0]        data_byte_i,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  output logic [LANE_W-1:0] hash_value_o
);

  logic [LANE_W-1:0] key_low_q, key_high_q;
  lanes_t            lanes_q, lanes_d;
  lanes_t            lanes_init;
  lanes_t            lanes_rst;
  lanes_t            round_out;
  logic [LANE_W-1:0] buf_q, buf_d;
  logic [LANE_W-1:0] msg_q, msg_d;
  logic [2:0]        pos_q, pos_d;
  logic [7:0]        len_q, len_d;
  logic [LANE_W-1:0] hash_q;
  logic [LANE_W-1:0] word_full;
  logic [LANE_W-1:0] word_last;

  assign stat_o.word_full = (pos_q == 3'd7);
  assign hash_value_o     = hash_q;

  assign word_full = {data_byte_i, buf_q[55:0]};
  assign word_last = {len_q, buf_q[55:0]};

  assign lanes_init = '{a: key_low_q ^ SIP_C0, b: key_high_q ^ SIP_C1,
                        c: key_low_q ^ SIP_C2, d: key_high_q ^ SIP_C3};
  assign lanes_rst  = '{a: KEY_LOW_RST ^ SIP_C0, b: KEY_HIGH_RST ^ SIP_C1,
                        c: KEY_LOW_RST ^ SIP_C2, d: KEY_HIGH_RST ^ SIP_C3};

  assign round_out = cmd_i.half_sel ? half_round1(lanes_q) : half_round0(lanes_q);

  always_comb begin
    lanes_d = lanes_q;
    buf_d   = buf_q;
    msg_d   = msg_q;
    pos_d   = pos_q;
    len_d   = len_q;
    if (cmd_i.accept) begin
      if (req_type_i == REQ_FINISH) begin
        msg_d     = word_last;
        lanes_d.d = lanes_q.d ^ word_last;
      end else begin
        len_d = len_q + 8'd1;
        if (pos_q == 3'd7) begin
          msg_d     = word_full;
          lanes_d.d = lanes_q.d ^ word_full;
          buf_d     = '0;
          pos_d     = '0;
        end else begin
          buf_d[pos_q*8 +: 8] = data_byte_i;
          pos_d               = pos_q + 3'd1;
        end
      end
    end else if (cmd_i.half) begin
      lanes_d = round_out;
      if (cmd_i.xor_msg) begin
        lanes_d.a = round_out.a ^ msg_q;
      end
      if (cmd_i.xor_fin) begin
        lanes_d.c = round_out.c ^ {{(LANE_W-8){1'b0}}, FIN_MASK};
      end
    end else if (cmd_i.emit) begin
      lanes_d = lanes_init;
      buf_d   = '0;
      pos_d   = '0;
      len_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= KEY_LOW_RST;
      key_high_q <= KEY_HIGH_RST;
      lanes_q    <= lanes_rst;
      buf_q      <= '0;
      pos_q      <= '0;
      len_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_KEY_LOW:  key_low_q  <= cfg_data_i;
          REG_KEY_HIGH: key_high_q <= cfg_data_i;
          default:      key_low_q  <= key_low_q;
        endcase
      end
      lanes_q <= lanes_d;
      buf_q   <= buf_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    msg_q <= msg_d;
    if (cmd_i.emit) begin
      hash_q <= lanes_q.a ^ lanes_q.b ^ lanes_q.c ^ lanes_q.d;
    end
  end

endmodule

// ===== hdl/siphash_2_4_byte_stream.sv =====
// ----------------------------------------------------------------------------
// siphash_2_4_byte_stream
// Keyed SipHash-2-4 over a byte stream with a 64-bit digest per message.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): req_type_i = 0 absorbs data_byte_i,
// req_type_i = 1 finishes the message. Output channel (out_valid_o/
// out_ready_i) carries hash_value_o, one transaction per finish.
// Config channel (cfg_valid_i/cfg_ready_o, always ready): index 0 key_low,
// index 1 key_high; write only while idle. A new key enters the lanes at
// the next digest load and applies to the messages after it.
// One shared half-round unit runs every round. in_ready_o is high only in
// idle, so no request is taken while rounds run or a digest loads. The
// eighth byte of a word is followed by two SipRounds; a finish runs accept,
// the rounds, then the digest load; out_valid_o rises the cycle after it.
// Absorbs are taken while a digest waits; a finish whose digest is ready
// holds in the load step until the previous digest is taken.
// Reset loads the default key and derives the lanes from it, clears the
// word buffer and counters; no digest is pending after reset.
// ----------------------------------------------------------------------------
module siphash_2_4_byte_stream
  import sip_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [7:0]        data_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [LANE_W-1:0] hash_value_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [LANE_W-1:0] cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  sip_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sip_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .req_type_i   (req_type_i),
    .data_byte_i  (data_byte_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .hash_value_o (hash_value_o)
  );

endmodule
